[hw/rtl/dlt_pkg.sv]
// ============================================================================
// dlt_pkg - shared types and constants for the delimited line tokenizer
// Mode, result kind, error and controller state codes, character constants,
// and the command and status bundles between controller and datapath.
// ============================================================================
package dlt_pkg;

    localparam int MAX_COLUMNS_DEF = 16;
    localparam int BLANK_DEPTH_DEF = 8;

    localparam int CH_W      = 8;
    localparam int KIND_W    = 2;
    localparam int COL_OUT_W = 5;
    localparam int ERR_W     = 2;

    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_QUOTE = 8'h22;
    localparam logic [CH_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CH_W-1:0] CH_SEMI  = 8'h3B;

    typedef enum logic [2:0] {
        MODE_START,
        MODE_PLAIN,
        MODE_QUOTED,
        MODE_AFTERQ,
        MODE_SKIP
    } mode_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_BYTE,
        KIND_FIELD_END,
        KIND_ROW_END,
        KIND_ERROR
    } kind_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NO_QUOTE,
        ERR_NO_SEP,
        ERR_TOO_MANY,
        ERR_BLANK_RUN
    } err_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_BLANKS,
        ST_CONTENT,
        ST_LINE_EOF,
        ST_PAD,
        ST_ROW_END,
        ST_SEP_EOF,
        ST_ERROR
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic  in_load;
        logic  mode_we;
        mode_t mode_val;
        logic  clear_field;
        logic  clear_row;
        logic  blank_push;
        logic  flush_start;
        logic  flush_step;
        logic  content_set;
        logic  col_inc;
        logic  pad_init;
        logic  pad_inc;
        logic  hdr_set;
        logic  hdr_clear;
        logic  emit;
        kind_t emit_kind;
        err_t  emit_err;
        logic  emit_last;
        logic  val_ram;
        logic  col_pad;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        mode_t mode;
        logic  is_zero;
        logic  is_quote;
        logic  is_sep;
        logic  is_space;
        logic  is_tab;
        logic  has_content;
        logic  blank_empty;
        logic  blank_full;
        logic  flush_last;
        logic  sep_limit;
        logic  hdr_valid;
        logic  pad_more;
        logic  out_free;
    } dp_status_t;

endpackage

[hw/rtl/dlt_ram.sv]
// ============================================================================
// dlt_ram - generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ============================================================================
module dlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/dlt_ctrl.sv]
// ============================================================================
// dlt_ctrl - tokenizer controller
// Decodes each accepted byte against the parse mode and sequences the
// result transactions (held blanks, field ends, padding, row end, errors).
// ============================================================================
module dlt_ctrl
    import dlt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  dp_status_t st,
    output ctrl_cmd_t  cmd
);

    state_t state_reg, state_next;
    err_t   err_reg, err_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            err_reg   <= ERR_NO_QUOTE;
        end
        else
        begin
            state_reg <= state_next;
            err_reg   <= err_next;
        end
    end

    assign item_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        logic do_line;
        logic do_sep;
        logic do_blank;
        logic do_content;
        logic do_fail;
        err_t fail_code;

        cmd        = '0;
        state_next = state_reg;
        err_next   = err_reg;
        do_line    = 1'b0;
        do_sep     = 1'b0;
        do_blank   = 1'b0;
        do_content = 1'b0;
        do_fail    = 1'b0;
        fail_code  = ERR_NO_QUOTE;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.in_load = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end

            ST_DISPATCH:
            begin
                state_next = ST_IDLE;
                unique case (st.mode)
                    MODE_SKIP:
                    begin
                        if (st.is_zero)
                        begin
                            cmd.clear_row = 1'b1;
                        end
                    end
                    MODE_QUOTED:
                    begin
                        if (st.is_zero)
                        begin
                            do_fail   = 1'b1;
                            fail_code = ERR_NO_QUOTE;
                        end
                        else if (st.is_quote)
                        begin
                            cmd.mode_we  = 1'b1;
                            cmd.mode_val = MODE_AFTERQ;
                        end
                        else if (st.is_space || st.is_tab)
                        begin
                            do_blank = 1'b1;
                        end
                        else
                        begin
                            do_content = 1'b1;
                        end
                    end
                    MODE_AFTERQ:
                    begin
                        if (st.is_zero)
                        begin
                            do_line = 1'b1;
                        end
                        else if (st.is_sep)
                        begin
                            do_sep = 1'b1;
                        end
                        else
                        begin
                            do_fail   = 1'b1;
                            fail_code = ERR_NO_SEP;
                        end
                    end
                    default:
                    begin
                        // field start or unquoted
                        if (st.mode == MODE_START && st.is_quote)
                        begin
                            cmd.clear_field = 1'b1;
                            cmd.mode_we     = 1'b1;
                            cmd.mode_val    = MODE_QUOTED;
                        end
                        else
                        begin
                            cmd.mode_we  = 1'b1;
                            cmd.mode_val = MODE_PLAIN;
                            if (st.is_zero)
                            begin
                                do_line = 1'b1;
                            end
                            else if (st.is_sep)
                            begin
                                do_sep = 1'b1;
                            end
                            else if (st.is_space)
                            begin
                                do_blank = 1'b1;
                            end
                            else
                            begin
                                do_content = 1'b1;
                            end
                        end
                    end
                endcase

                if (do_line)
                begin
                    state_next = ST_LINE_EOF;
                end
                if (do_sep)
                begin
                    state_next = ST_SEP_EOF;
                end
                if (do_blank && st.has_content)
                begin
                    if (st.blank_full)
                    begin
                        do_fail   = 1'b1;
                        fail_code = ERR_BLANK_RUN;
                    end
                    else
                    begin
                        cmd.blank_push = 1'b1;
                    end
                end
                if (do_content)
                begin
                    if (!st.blank_empty)
                    begin
                        cmd.flush_start = 1'b1;
                        state_next      = ST_BLANKS;
                    end
                    else if (st.out_free)
                    begin
                        // fast path: lone content byte goes straight out
                        cmd.emit        = 1'b1;
                        cmd.emit_kind   = KIND_BYTE;
                        cmd.emit_last   = 1'b1;
                        cmd.content_set = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_CONTENT;
                    end
                end
                if (do_fail)
                begin
                    err_next   = fail_code;
                    state_next = ST_ERROR;
                end
            end

            ST_BLANKS:
            begin
                if (st.out_free)
                begin
                    cmd.emit       = 1'b1;
                    cmd.emit_kind  = KIND_BYTE;
                    cmd.val_ram    = 1'b1;
                    cmd.flush_step = 1'b1;
                    if (st.flush_last)
                    begin
                        state_next = ST_CONTENT;
                    end
                end
            end

            ST_CONTENT:
            begin
                if (st.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_kind   = KIND_BYTE;
                    cmd.emit_last   = 1'b1;
                    cmd.content_set = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            ST_LINE_EOF:
            begin
                if (st.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_kind   = KIND_FIELD_END;
                    cmd.clear_field = 1'b1;
                    cmd.pad_init    = 1'b1;
                    state_next      = ST_PAD;
                end
            end

            ST_PAD:
            begin
                if (!st.pad_more)
                begin
                    state_next = ST_ROW_END;
                end
                else if (st.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_FIELD_END;
                    cmd.col_pad   = 1'b1;
                    cmd.pad_inc   = 1'b1;
                end
            end

            ST_ROW_END:
            begin
                if (st.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_ROW_END;
                    cmd.col_pad   = 1'b1;
                    cmd.emit_last = 1'b1;
                    cmd.hdr_set   = !st.hdr_valid;
                    cmd.clear_row = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            ST_SEP_EOF:
            begin
                if (st.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_kind   = KIND_FIELD_END;
                    cmd.emit_last   = !st.sep_limit;
                    cmd.clear_field = 1'b1;
                    if (st.sep_limit)
                    begin
                        err_next   = ERR_TOO_MANY;
                        state_next = ST_ERROR;
                    end
                    else
                    begin
                        cmd.col_inc  = 1'b1;
                        cmd.mode_we  = 1'b1;
                        cmd.mode_val = MODE_START;
                        state_next   = ST_IDLE;
                    end
                end
            end

            ST_ERROR:
            begin
                if (st.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_ERROR;
                    cmd.emit_err  = err_reg;
                    cmd.emit_last = 1'b1;
                    if (err_reg == ERR_NO_QUOTE)
                    begin
                        // line already over: back to a fresh row
                        cmd.clear_row = 1'b1;
                    end
                    else
                    begin
                        cmd.clear_field = 1'b1;
                        cmd.mode_we     = 1'b1;
                        cmd.mode_val    = MODE_SKIP;
                    end
                    cmd.hdr_clear = (err_reg == ERR_TOO_MANY);
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/dlt_datapath.sv]
// ============================================================================
// dlt_datapath - tokenizer datapath
// Parse state, held blank store, column and header tracking, and the
// result output register.
// ============================================================================
module dlt_datapath
    import dlt_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
    parameter int BLANK_DEPTH = BLANK_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [CH_W-1:0]      ch,
    input  logic                 result_ready,
    input  ctrl_cmd_t            cmd,
    output dp_status_t           st,
    output logic                 result_valid,
    output logic [KIND_W-1:0]    kind,
    output logic [CH_W-1:0]      value,
    output logic [COL_OUT_W-1:0] column,
    output logic                 is_header,
    output logic [ERR_W-1:0]     err_code,
    output logic                 last
);

    localparam int CW  = $clog2(MAX_COLUMNS + 1);
    localparam int BCW = $clog2(BLANK_DEPTH + 1);
    localparam int AW  = (BLANK_DEPTH > 1) ? $clog2(BLANK_DEPTH) : 1;
    localparam logic [CW:0]    MAX_COL_EXT = (CW + 1)'(MAX_COLUMNS);
    localparam logic [BCW-1:0] DEPTH_B     = BCW'(BLANK_DEPTH);

    logic [CH_W-1:0]      ch_reg;
    logic                 hdr_flag_reg;
    mode_t                mode_reg;
    logic [BCW-1:0]       blank_cnt_reg;
    logic                 has_content_reg;
    logic [CW-1:0]        col_reg;
    logic                 hdr_valid_reg;
    logic [CW-1:0]        hdr_cols_reg;
    logic [CW-1:0]        pad_reg;
    logic [AW-1:0]        rd_idx_reg, rd_idx_next;

    logic                 out_valid_reg;
    kind_t                out_kind_reg;
    logic [CH_W-1:0]      out_value_reg;
    logic [COL_OUT_W-1:0] out_col_reg;
    logic                 out_hdr_reg;
    err_t                 out_err_reg;
    logic                 out_last_reg;

    logic [CH_W-1:0]      ram_rdata;
    logic [CW:0]          col_plus1;
    logic [CW:0]          col_limit;

    // blank store, read port follows the flush index
    always_comb
    begin
        rd_idx_next = rd_idx_reg;
        if (cmd.flush_start)
        begin
            rd_idx_next = '0;
        end
        else if (cmd.flush_step)
        begin
            rd_idx_next = rd_idx_reg + AW'(1);
        end
    end

    dlt_ram #(
        .WIDTH (CH_W),
        .DEPTH (BLANK_DEPTH)
    ) u_blank_ram (
        .clk   (clk),
        .we    (cmd.blank_push),
        .waddr (blank_cnt_reg[AW-1:0]),
        .wdata (ch_reg),
        .raddr (rd_idx_next),
        .rdata (ram_rdata)
    );

    assign col_plus1 = {1'b0, col_reg} + (CW + 1)'(1);
    assign col_limit = hdr_valid_reg ? {1'b0, hdr_cols_reg} : MAX_COL_EXT;

    always_comb
    begin
        st.mode        = mode_reg;
        st.is_zero     = (ch_reg == CH_NUL);
        st.is_quote    = (ch_reg == CH_QUOTE);
        st.is_sep      = (ch_reg == CH_COMMA) || (ch_reg == CH_SEMI) || (ch_reg == CH_TAB);
        st.is_space    = (ch_reg == CH_SPACE);
        st.is_tab      = (ch_reg == CH_TAB);
        st.has_content = has_content_reg;
        st.blank_empty = (blank_cnt_reg == '0);
        st.blank_full  = (blank_cnt_reg >= DEPTH_B);
        st.flush_last  = ((BCW'(rd_idx_reg) + BCW'(1)) == blank_cnt_reg);
        st.sep_limit   = (col_plus1 >= col_limit);
        st.hdr_valid   = hdr_valid_reg;
        st.pad_more    = (pad_reg < hdr_cols_reg);
        st.out_free    = !out_valid_reg || result_ready;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            ch_reg       <= ch;
            hdr_flag_reg <= !hdr_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_START;
            blank_cnt_reg   <= '0;
            has_content_reg <= 1'b0;
            col_reg         <= '0;
            hdr_valid_reg   <= 1'b0;
            hdr_cols_reg    <= '0;
            pad_reg         <= '0;
            rd_idx_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            rd_idx_reg <= rd_idx_next;

            if (cmd.clear_row)
            begin
                mode_reg <= MODE_START;
            end
            else if (cmd.mode_we)
            begin
                mode_reg <= cmd.mode_val;
            end

            if (cmd.clear_field || cmd.clear_row || cmd.content_set)
            begin
                blank_cnt_reg <= '0;
            end
            else if (cmd.blank_push)
            begin
                blank_cnt_reg <= blank_cnt_reg + BCW'(1);
            end

            if (cmd.clear_field || cmd.clear_row)
            begin
                has_content_reg <= 1'b0;
            end
            else if (cmd.content_set)
            begin
                has_content_reg <= 1'b1;
            end

            if (cmd.clear_row)
            begin
                col_reg <= '0;
            end
            else if (cmd.col_inc)
            begin
                col_reg <= col_reg + CW'(1);
            end

            if (cmd.pad_init)
            begin
                pad_reg <= col_plus1[CW-1:0];
            end
            else if (cmd.pad_inc)
            begin
                pad_reg <= pad_reg + CW'(1);
            end

            if (cmd.hdr_clear)
            begin
                hdr_valid_reg <= 1'b0;
                hdr_cols_reg  <= '0;
            end
            else if (cmd.hdr_set)
            begin
                hdr_valid_reg <= 1'b1;
                hdr_cols_reg  <= pad_reg;
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_kind_reg  <= cmd.emit_kind;
            out_value_reg <= (cmd.emit_kind == KIND_BYTE) ?
                             (cmd.val_ram ? ram_rdata : ch_reg) : '0;
            out_col_reg   <= COL_OUT_W'(cmd.col_pad ? pad_reg : col_reg);
            out_hdr_reg   <= hdr_flag_reg;
            out_err_reg   <= (cmd.emit_kind == KIND_ERROR) ? cmd.emit_err : ERR_NO_QUOTE;
            out_last_reg  <= cmd.emit_last;
        end
    end

    assign result_valid = out_valid_reg;
    assign kind         = out_kind_reg;
    assign value        = out_value_reg;
    assign column       = out_col_reg;
    assign is_header    = out_hdr_reg;
    assign err_code     = out_err_reg;
    assign last         = out_last_reg;

    a_blank_bound: assert property (@(posedge clk) disable iff (!rst_n)
        blank_cnt_reg <= DEPTH_B)
        else $error("held blank count beyond store depth");

    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, col_reg} < MAX_COL_EXT)
        else $error("column index beyond column limit");

    a_hdr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_valid_reg |-> (hdr_cols_reg != '0))
        else $error("valid header with zero columns");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || result_ready))
        else $error("result overwritten before taken");

    a_flush_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush_step |-> (blank_cnt_reg != '0))
        else $error("flush step with no held blanks");

endmodule

[hw/rtl/delimited_line_tokenizer_core.sv]
// ============================================================================
// delimited_line_tokenizer_core - CSV-style line tokenizer, top level
// Splits a byte stream of lines into field bytes, field ends, row ends and
// error transactions; pads short rows to the header's column count.
// ============================================================================
// Usage:
//   Input channel (item_valid/item_ready, ch): one byte per transaction, a
//   zero byte closes the line. Output channel (result_valid/result_ready):
//   kind, value, column, is_header, err_code and last; last marks the final
//   result caused by one input byte. A byte may cause no result at all.
//   Timing: a byte is accepted from the idle state and decoded in the next
//   cycle. Held blanks flushed before a content byte go out one blank store
//   read per cycle while the receiver takes them, then the byte itself. A
//   separator issues a field end (and an error on column overflow); an end
//   of line issues a field end, the padded fields and a row end; an error
//   issues one error result. The controller sequences at most one result
//   per cycle and holds while the receiver stalls.
//   The result register decouples the channels: a new byte is taken while a
//   finished result still waits. When the receiver stalls, the controller
//   holds in its current step and stops accepting input once a further
//   result has to be issued.
//   Reset: parse mode returns to field start, no header is held, counters
//   clear and no result is pending. No clearing pass is needed.
// ============================================================================
module delimited_line_tokenizer_core
    import dlt_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
    parameter int BLANK_DEPTH = BLANK_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  logic [CH_W-1:0]      ch,
    output logic                 result_valid,
    input  logic                 result_ready,
    output logic [KIND_W-1:0]    kind,
    output logic [CH_W-1:0]      value,
    output logic [COL_OUT_W-1:0] column,
    output logic                 is_header,
    output logic [ERR_W-1:0]     err_code,
    output logic                 last
);

    ctrl_cmd_t  cmd;
    dp_status_t st;

    // sequencing: decode of each byte and the order of result transactions
    dlt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .st         (st),
        .cmd        (cmd)
    );

    // parse state, blank store, header tracking and output register
    dlt_datapath #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .BLANK_DEPTH (BLANK_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ch           (ch),
        .result_ready (result_ready),
        .cmd          (cmd),
        .st           (st),
        .result_valid (result_valid),
        .kind         (kind),
        .value        (value),
        .column       (column),
        .is_header    (is_header),
        .err_code     (err_code),
        .last         (last)
    );

endmodule

[dv/dlt_token_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// dlt_token_checker - scoreboard for the delimited line tokenizer
// Watches both channels, predicts the results of every accepted byte and
// compares the result channel against them in order.
// ============================================================================
module dlt_token_checker
    import dlt_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
    parameter int BLANK_DEPTH = BLANK_DEPTH_DEF,
    parameter int MAX_REPORTS = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  logic                 item_ready,
    input  logic [CH_W-1:0]      ch,
    input  logic                 result_valid,
    input  logic                 result_ready,
    input  logic [KIND_W-1:0]    kind,
    input  logic [CH_W-1:0]      value,
    input  logic [COL_OUT_W-1:0] column,
    input  logic                 is_header,
    input  logic [ERR_W-1:0]     err_code,
    input  logic                 last,
    output int                   fail_count,
    output int                   due_count
);

    typedef struct packed {
        kind_t                kind;
        logic [CH_W-1:0]      value;
        logic [COL_OUT_W-1:0] column;
        logic                 hdr;
        err_t                 err;
        logic                 last;
    } token_t;

    // tokenizer state as predicted
    mode_t           scan_mode;
    logic [CH_W-1:0] held_blanks [BLANK_DEPTH];
    int unsigned     held_cnt;
    bit              in_field;
    int unsigned     col_idx;
    bit              hdr_known;
    int unsigned     hdr_cols;
    bit              row_hdr;

    token_t step_tokens[$];
    token_t tokens_due[$];

    // err_code reads zero outside error tokens, hence ERR_NO_QUOTE as filler
    function automatic void push_token(kind_t k, logic [CH_W-1:0] v, int unsigned c,
                                       err_t e);
        token_t t;
        t.kind   = k;
        t.value  = v;
        t.column = c[COL_OUT_W-1:0];
        t.hdr    = row_hdr;
        t.err    = e;
        t.last   = 1'b0;
        step_tokens.push_back(t);
    endfunction

    function automatic void drop_field();
        held_cnt = 0;
        in_field = 1'b0;
    endfunction

    function automatic void drop_row();
        drop_field();
        col_idx   = 0;
        scan_mode = MODE_START;
    endfunction

    function automatic void abort_line(err_t e);
        push_token(KIND_ERROR, CH_NUL, col_idx, e);
        drop_field();
        scan_mode = MODE_SKIP;
    endfunction

    function automatic void take_content(logic [CH_W-1:0] c);
        for (int i = 0; i < held_cnt; i++)
            push_token(KIND_BYTE, held_blanks[i], col_idx, ERR_NO_QUOTE);
        held_cnt = 0;
        in_field = 1'b1;
        push_token(KIND_BYTE, c, col_idx, ERR_NO_QUOTE);
    endfunction

    // leading blanks vanish; inner ones wait for the next content byte
    function automatic void take_blank(logic [CH_W-1:0] c);
        if (!in_field)
            return;
        if (held_cnt >= BLANK_DEPTH)
        begin
            abort_line(ERR_BLANK_RUN);
            return;
        end
        held_blanks[held_cnt] = c;
        held_cnt++;
    endfunction

    function automatic void close_field();
        push_token(KIND_FIELD_END, CH_NUL, col_idx, ERR_NO_QUOTE);
        drop_field();
    endfunction

    function automatic void take_separator();
        int unsigned limit;
        limit = hdr_known ? hdr_cols : MAX_COLUMNS;
        close_field();
        if (col_idx + 1 >= limit)
        begin
            push_token(KIND_ERROR, CH_NUL, col_idx, ERR_TOO_MANY);
            hdr_known = 1'b0;
            hdr_cols  = 0;
            scan_mode = MODE_SKIP;
        end
        else
        begin
            col_idx++;
            scan_mode = MODE_START;
        end
    endfunction

    function automatic void take_line_end();
        int unsigned fields;
        close_field();
        fields = col_idx + 1;
        if (hdr_known)
        begin
            while (fields < hdr_cols)
            begin
                push_token(KIND_FIELD_END, CH_NUL, fields, ERR_NO_QUOTE);
                fields++;
            end
        end
        else
        begin
            hdr_known = 1'b1;
            hdr_cols  = fields;
        end
        push_token(KIND_ROW_END, CH_NUL, fields, ERR_NO_QUOTE);
        drop_row();
    endfunction

    function automatic bit is_separator(logic [CH_W-1:0] c);
        return c == CH_COMMA || c == CH_SEMI || c == CH_TAB;
    endfunction

    function automatic void predict_byte(logic [CH_W-1:0] c);
        step_tokens.delete();
        row_hdr = !hdr_known;
        case (scan_mode)
            MODE_SKIP:
            begin
                if (c == CH_NUL)
                    drop_row();
            end
            MODE_QUOTED:
            begin
                if (c == CH_NUL)
                begin
                    push_token(KIND_ERROR, CH_NUL, col_idx, ERR_NO_QUOTE);
                    drop_row();
                end
                else if (c == CH_QUOTE)
                    scan_mode = MODE_AFTERQ;
                else if (c == CH_SPACE || c == CH_TAB)
                    take_blank(c);
                else
                    take_content(c);
            end
            MODE_AFTERQ:
            begin
                if (c == CH_NUL)
                    take_line_end();
                else if (is_separator(c))
                    take_separator();
                else
                    abort_line(ERR_NO_SEP);
            end
            default:
            begin
                if (scan_mode == MODE_START && c == CH_QUOTE)
                begin
                    drop_field();
                    scan_mode = MODE_QUOTED;
                end
                else
                begin
                    scan_mode = MODE_PLAIN;
                    if (c == CH_NUL)
                        take_line_end();
                    else if (is_separator(c))
                        take_separator();
                    else if (c == CH_SPACE)
                        take_blank(c);
                    else
                        take_content(c);
                end
            end
        endcase
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].last = 1'b1;
        foreach (step_tokens[i])
            tokens_due.push_back(step_tokens[i]);
    endfunction

    function automatic void flag_error(string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t: %s", $time, msg);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        token_t got;
        token_t want;
        if (!rst_n)
        begin
            hdr_known = 1'b0;
            hdr_cols  = 0;
            row_hdr   = 1'b1;
            drop_row();
            tokens_due.delete();
            due_count <= 0;
        end
        else
        begin
            if (item_valid && item_ready)
                predict_byte(ch);
            if (result_valid && result_ready)
            begin
                got.kind   = kind_t'(kind);
                got.value  = value;
                got.column = column;
                got.hdr    = is_header;
                got.err    = err_t'(err_code);
                got.last   = last;
                if (tokens_due.size() == 0)
                    flag_error($sformatf("unexpected result kind=%0d value=%0h column=%0d",
                                         kind, value, column));
                else
                begin
                    want = tokens_due.pop_front();
                    if (got !== want)
                        flag_error($sformatf({"mismatch: want kind=%0d value=%0h col=%0d ",
                            "hdr=%0d err=%0d last=%0d, got kind=%0d value=%0h col=%0d ",
                            "hdr=%0d err=%0d last=%0d"},
                            want.kind, want.value, want.column, want.hdr, want.err,
                            want.last, kind, value, column, is_header, err_code, last));
                end
            end
            due_count <= tokens_due.size();
        end
    end

endmodule

[dv/delimited_line_tokenizer_core_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// delimited_line_tokenizer_core_tb - testbench top for the line tokenizer
// Feeds directed lines covering each corner of the field grammar, then
// random lines, mostly well-formed with random content plus some noise,
// under several idle/stall mixes. A checker beside the block scores results.
// ============================================================================
module delimited_line_tokenizer_core_tb;
    import dlt_pkg::*;

    localparam int MAX_COLUMNS  = MAX_COLUMNS_DEF;
    localparam int BLANK_DEPTH  = BLANK_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 320;
    localparam int PHASE_ITEMS  = 80;     // bytes per idle/stall phase
    localparam int DRAIN_CYCLES = 40;     // drain margin for the worst line end (15 pads)
    localparam int STALL_LIMIT  = 2000;   // cycles without any transaction
    localparam int N_DIRECTED   = 35;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 item_valid = 1'b0;
    logic                 item_ready;
    logic [CH_W-1:0]      ch = CH_NUL;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    logic [KIND_W-1:0]    kind;
    logic [CH_W-1:0]      value;
    logic [COL_OUT_W-1:0] column;
    logic                 is_header;
    logic [ERR_W-1:0]     err_code;
    logic                 last;

    int fail_count;
    int due_count;
    int sent_items = 0;
    int quiet_cycles = 0;
    int idle_pct = 0;     // chance per cycle that the sender holds off
    int stall_pct = 0;    // chance per cycle that the receiver stalls

    // Directed lines, in order:
    //   "a b";<FF>    header of two columns, quoted field with inner blank,
    //                 top byte value
    //   <empty>       empty line, padded up to the header width
    //   <sp>"<tab><sp> leading blank dropped, quote that is not first is a
    //                 plain byte, tab separator, all-blank field goes empty
    //   "" <sp>       blank after the closing quote: missing separator
    //   "<01>         line ends inside quotes: missing closing quote
    //   ,,            third field over a two-column header: header dropped
    //   a + 9 blanks  ninth held blank overflows the blank store
    logic [CH_W-1:0] directed_seq [N_DIRECTED] = '{
        CH_QUOTE, 8'h61, CH_SPACE, 8'h62, CH_QUOTE, CH_SEMI, 8'hFF, CH_NUL,
        CH_NUL,
        CH_SPACE, CH_QUOTE, CH_TAB, CH_SPACE, CH_NUL,
        CH_QUOTE, CH_QUOTE, CH_SPACE, CH_NUL,
        CH_QUOTE, 8'h01, CH_NUL,
        CH_COMMA, CH_COMMA, CH_NUL,
        8'h61, CH_SPACE, CH_SPACE, CH_SPACE, CH_SPACE, CH_SPACE, CH_SPACE,
        CH_SPACE, CH_SPACE, CH_SPACE, CH_NUL
    };

    delimited_line_tokenizer_core #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .BLANK_DEPTH (BLANK_DEPTH)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .ch           (ch),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .kind         (kind),
        .value        (value),
        .column       (column),
        .is_header    (is_header),
        .err_code     (err_code),
        .last         (last)
    );

    dlt_token_checker #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .BLANK_DEPTH (BLANK_DEPTH)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .ch           (ch),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .kind         (kind),
        .value        (value),
        .column       (column),
        .is_header    (is_header),
        .err_code     (err_code),
        .last         (last),
        .fail_count   (fail_count),
        .due_count    (due_count)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Receiver: stalls at random with the current phase's rate.
    always @(posedge clk)
    begin
        result_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: any transaction on either channel restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // One input transaction. Idle gaps come first, so valid stays high
    // across back-to-back bytes and is set only once per time step.
    task automatic send_byte(input logic [CH_W-1:0] b);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        ch         <= b;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        sent_items++;
    endtask

    // Field byte that carries no meaning to the grammar. Mostly letters,
    // sometimes any byte so every bit of ch toggles.
    function automatic logic [CH_W-1:0] pick_content();
        logic [CH_W-1:0] b;
        if ($urandom_range(3) != 0)
            b = CH_W'(8'h61 + $urandom_range(25));
        else
        begin
            b = CH_W'($urandom_range(255));
            while (b == CH_NUL || b == CH_COMMA || b == CH_SEMI || b == CH_TAB ||
                   b == CH_SPACE || b == CH_QUOTE)
                b = CH_W'($urandom_range(255));
        end
        return b;
    endfunction

    function automatic logic [CH_W-1:0] pick_sep();
        int r;
        r = $urandom_range(2);
        return (r == 0) ? CH_COMMA : (r == 1) ? CH_SEMI : CH_TAB;
    endfunction

    // Blank run length; now and then one or two past the blank store depth.
    function automatic int pick_run_len();
        if ($urandom_range(11) == 0)
            return $urandom_range(BLANK_DEPTH + 1, BLANK_DEPTH + 2);
        return $urandom_range(1, 3);
    endfunction

    task automatic send_blanks(input int n, input bit with_tabs);
        for (int i = 0; i < n; i++)
            send_byte((with_tabs && $urandom_range(2) == 0) ? CH_TAB : CH_SPACE);
    endtask

    // Unquoted field: optional leading blanks, content with inner blank
    // runs and the odd quote after the first byte, then trailing blanks.
    task automatic send_plain_field();
        int len;
        len = $urandom_range(0, 5);
        send_blanks($urandom_range(0, 2), 1'b0);
        for (int i = 0; i < len; i++)
        begin
            if (i > 0 && $urandom_range(4) == 0)
                send_blanks(pick_run_len(), 1'b0);
            send_byte((i > 0 && $urandom_range(9) == 0) ? CH_QUOTE : pick_content());
        end
        send_blanks($urandom_range(1) ? 0 : pick_run_len(), 1'b0);
    endtask

    // Quoted field: separators and tabs inside are data. Sometimes broken:
    // no closing quote, or junk right after it.
    task automatic send_quoted_field();
        int len;
        int r;
        len = $urandom_range(0, 5);
        if ($urandom_range(7) == 0)
            send_byte(CH_SPACE);    // demotes the quote to a plain byte
        send_byte(CH_QUOTE);
        send_blanks($urandom_range(0, 2), 1'b1);
        for (int i = 0; i < len; i++)
        begin
            if (i > 0 && $urandom_range(3) == 0)
                send_blanks(pick_run_len(), 1'b1);
            send_byte(($urandom_range(5) == 0) ? pick_sep() : pick_content());
        end
        send_blanks($urandom_range(0, 2), 1'b1);
        r = $urandom_range(19);
        if (r != 0)
        begin
            send_byte(CH_QUOTE);
            if (r == 1)
                send_byte(CH_SPACE);
            else if (r == 2)
                send_byte(pick_content());
        end
    endtask

    task automatic send_line(input int nfields);
        for (int f = 0; f < nfields; f++)
        begin
            if ($urandom_range(3) == 0)
                send_quoted_field();
            else
                send_plain_field();
            if (f < nfields - 1)
                send_byte(pick_sep());
        end
        send_byte(CH_NUL);
    endtask

    initial
    begin
        int r;
        int phase;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part runs with both sides always ready
        foreach (directed_seq[i])
            send_byte(directed_seq[i]);

        // Random part. Phases rotate: no idling, sender idle, receiver
        // stalling, both sides idling lightly.
        while (sent_items < N_DIRECTED + RANDOM_ITEMS)
        begin
            phase = ((sent_items - N_DIRECTED) / PHASE_ITEMS) % 4;
            idle_pct  = (phase == 1) ? 60 : (phase == 3) ? 16 : 0;
            stall_pct = (phase == 2) ? 60 : (phase == 3) ? 16 : 0;
            r = $urandom_range(9);
            if (r == 0)
            begin
                // noise line: raw bytes, a zero among them ends it early
                repeat ($urandom_range(1, 12))
                    send_byte(CH_W'($urandom_range(255)));
                send_byte(CH_NUL);
            end
            else if (r < 6)
                send_line($urandom_range(1, 4));
            else if (r < 9)
                send_line($urandom_range(5, MAX_COLUMNS));
            else
                send_line($urandom_range(MAX_COLUMNS + 1, MAX_COLUMNS + 2));
        end
        item_valid <= 1'b0;

        // due_count is a registered copy of the checker's queue size
        @(posedge clk);
        while (due_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
